[rtl/dsrs_pkg.sv]
`timescale 1ns / 1ps

package dsrs_pkg;

  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned DebounceWidth = 16;
  localparam int unsigned GapWidth      = 24;
  localparam int unsigned TempWidth     = 12;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 24;

  // Status codes
  localparam logic [1:0] StatusOff     = 2'd0;
  localparam logic [1:0] StatusOn      = 2'd1;
  localparam logic [1:0] StatusUnknown = 2'd2;

  // Report kinds
  localparam logic KindStatus = 1'b0;
  localparam logic KindTemp   = 1'b1;

  localparam logic signed [TempWidth-1:0] TempReset = -12'sd1270;

  localparam logic [DebounceWidth-1:0] DebounceReset  = 16'd100;
  localparam logic [GapWidth-1:0]      MinGapReset    = 24'd1000;
  localparam logic [GapWidth-1:0]      PeriodicReset  = 24'd60000;
  localparam logic [TempWidth-1:0]     ThresholdReset = 12'd5;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgDebounce  = 3'd0,
    CfgMinGap    = 3'd1,
    CfgPeriodic  = 3'd2,
    CfgThreshold = 3'd3,
    CfgInvert    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeWidth-1:0]        time_ms;
    logic                        raw_status;
    logic                        temp_valid;
    logic signed [TempWidth-1:0] temp_sample;
  } dsrs_in_t;

  typedef struct packed {
    logic                        report_kind;
    logic [1:0]                  status_value;
    logic signed [TempWidth-1:0] temp_value;
  } dsrs_out_t;

  typedef struct packed {
    logic [DebounceWidth-1:0] debounce_ms;
    logic [GapWidth-1:0]      min_report_gap_ms;
    logic [GapWidth-1:0]      periodic_gap_ms;
    logic [TempWidth-1:0]     temp_threshold;
    logic                     invert_status;
  } dsrs_cfg_t;

  typedef struct packed {
    logic [1:0]                  last_raw;
    logic [TimeWidth-1:0]        unstable_since;
    logic [1:0]                  stable_status;
    logic [1:0]                  reported_status;
    logic signed [TempWidth-1:0] latest_temp;
    logic signed [TempWidth-1:0] reported_temp;
    logic [TimeWidth-1:0]        last_report_time;
    logic                        periodic_turn;
  } dsrs_state_t;

endpackage

[rtl/debounced_status_report_scheduler_core.sv]
`timescale 1ns / 1ps

// Status and temperature report scheduler. Takes one tick transaction per clock
// unless the output stalls, and gives at most one report per tick. A tick is
// accepted into the input register; its report is then loaded into the result
// register, which drives the output transaction. The decision logic computes
// the next state combinationally; while a report waits on the output, the next
// tick is held in the input register and further ticks stall. Ticks that cause no
// report produce no output transaction. Configuration writes are always ready;
// registers at index 5 and above are ignored.
module debounced_status_report_scheduler_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dsrs_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [dsrs_pkg::CfgDataWidth-1:0]     cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  dsrs_pkg::dsrs_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output dsrs_pkg::dsrs_out_t                   out_data_o
);
  import dsrs_pkg::*;

  dsrs_cfg_t   cfg_q;
  dsrs_state_t state_q, state_d;
  dsrs_in_t    in_q;
  logic        in_valid_q;
  dsrs_out_t   out_q, result;
  logic        out_valid_q, out_valid_d;
  logic        report;
  logic        proc;

  assign cfg_ready_o = 1'b1;
  assign proc        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || proc;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  dsrs_decide u_decide (
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .report_o (report),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = report;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= DebounceReset;
      cfg_q.min_report_gap_ms <= MinGapReset;
      cfg_q.periodic_gap_ms   <= PeriodicReset;
      cfg_q.temp_threshold    <= ThresholdReset;
      cfg_q.invert_status     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgDebounce:  cfg_q.debounce_ms       <= cfg_data_i[DebounceWidth-1:0];
        CfgMinGap:    cfg_q.min_report_gap_ms <= cfg_data_i[GapWidth-1:0];
        CfgPeriodic:  cfg_q.periodic_gap_ms   <= cfg_data_i[GapWidth-1:0];
        CfgThreshold: cfg_q.temp_threshold    <= cfg_data_i[TempWidth-1:0];
        CfgInvert:    cfg_q.invert_status     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.last_raw         <= StatusUnknown;
      state_q.unstable_since   <= '0;
      state_q.stable_status    <= StatusUnknown;
      state_q.reported_status  <= StatusUnknown;
      state_q.latest_temp      <= TempReset;
      state_q.reported_temp    <= TempReset;
      state_q.last_report_time <= '0;
      state_q.periodic_turn    <= KindStatus;
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (proc && report) begin
      out_q <= result;
    end
  end

endmodule

[rtl/dsrs_decide.sv]
`timescale 1ns / 1ps

module dsrs_decide (
  input  dsrs_pkg::dsrs_in_t    item_i,
  input  dsrs_pkg::dsrs_cfg_t   cfg_i,
  input  dsrs_pkg::dsrs_state_t state_i,
  output dsrs_pkg::dsrs_state_t state_o,
  output logic                  report_o,
  output dsrs_pkg::dsrs_out_t   result_o
);
  import dsrs_pkg::*;

  logic                        st_bit;
  logic [1:0]                  st_code;
  logic                        changed;
  logic [TimeWidth-1:0]        stable_for;
  logic [TimeWidth-1:0]        since_report;
  logic signed [TempWidth-1:0] cur_temp;
  logic signed [TempWidth:0]   temp_diff;
  logic [TempWidth:0]          temp_abs;

  assign st_bit       = item_i.raw_status ^ cfg_i.invert_status;
  assign st_code      = {1'b0, st_bit};
  assign changed      = (st_code != state_i.last_raw);
  assign stable_for   = item_i.time_ms - state_i.unstable_since;
  assign since_report = item_i.time_ms - state_i.last_report_time;
  assign cur_temp     = item_i.temp_valid ? item_i.temp_sample : state_i.latest_temp;
  assign temp_diff    = {cur_temp[TempWidth-1], cur_temp}
                      - {state_i.reported_temp[TempWidth-1], state_i.reported_temp};
  assign temp_abs     = temp_diff[TempWidth] ? (~temp_diff + 1'b1) : temp_diff;

  always_comb begin
    state_o             = state_i;
    report_o            = 1'b0;
    state_o.latest_temp = cur_temp;

    // A change restarts the stability window, so it can never pass on that tick.
    if (changed) begin
      state_o.last_raw       = st_code;
      state_o.unstable_since = item_i.time_ms;
    end else if (stable_for > {{(TimeWidth-DebounceWidth){1'b0}}, cfg_i.debounce_ms}) begin
      state_o.stable_status = st_code;
    end

    result_o.report_kind  = KindStatus;
    result_o.status_value = state_o.stable_status;
    result_o.temp_value   = cur_temp;

    if (since_report > {{(TimeWidth-GapWidth){1'b0}}, cfg_i.min_report_gap_ms}) begin
      if (state_o.stable_status != state_i.reported_status) begin
        report_o                 = 1'b1;
        state_o.reported_status  = state_o.stable_status;
        state_o.last_report_time = item_i.time_ms;
      end else if (temp_abs > {1'b0, cfg_i.temp_threshold}) begin
        report_o                 = 1'b1;
        result_o.report_kind     = KindTemp;
        state_o.reported_temp    = cur_temp;
        state_o.last_report_time = item_i.time_ms;
      end else if (since_report > {{(TimeWidth-GapWidth){1'b0}}, cfg_i.periodic_gap_ms}) begin
        report_o                 = 1'b1;
        result_o.report_kind     = state_i.periodic_turn;
        state_o.periodic_turn    = ~state_i.periodic_turn;
        state_o.last_report_time = item_i.time_ms;
        if (state_i.periodic_turn == KindStatus) begin
          state_o.reported_status = state_o.stable_status;
        end else begin
          state_o.reported_temp = cur_temp;
        end
      end
    end
  end

endmodule

[dv/debounced_status_report_scheduler_core_tb.sv]
`timescale 1ns / 1ps

module debounced_status_report_scheduler_core_tb;
  import dsrs_pkg::*;

  localparam logic [CfgIdxWidth-1:0] CfgSpareFirst = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CfgSpareLast  = 3'd7;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 10;

  typedef enum bit {Predicted, Tabulated} row_src_e;

  typedef struct {
    dsrs_in_t  tick;
    row_src_e  src;
    bit        has_rpt;
    dsrs_out_t rpt;
  } tick_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  dsrs_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  dsrs_out_t out_data_o;

  // table expectation that travels with the transaction on the input side
  row_src_e tick_src = Predicted;
  bit tick_has = 1'b0;
  dsrs_out_t tick_rpt = '0;

  always #2 clk_i = ~clk_i;

  debounced_status_report_scheduler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // scheduler mirror: configuration
  logic [DebounceWidth-1:0] debounce_set  = DebounceReset;
  logic [GapWidth-1:0]      min_gap_set   = MinGapReset;
  logic [GapWidth-1:0]      periodic_set  = PeriodicReset;
  logic [TempWidth-1:0]     threshold_set = ThresholdReset;
  logic                     invert_set    = 1'b0;

  // scheduler mirror: state
  logic [1:0]                  seen_raw       = StatusUnknown;
  logic [TimeWidth-1:0]        raw_since      = '0;
  logic [1:0]                  settled_status = StatusUnknown;
  logic [1:0]                  sent_status    = StatusUnknown;
  logic signed [TempWidth-1:0] temp_now       = TempReset;
  logic signed [TempWidth-1:0] sent_temp      = TempReset;
  logic [TimeWidth-1:0]        last_sent_ms   = '0;
  logic                        temp_turn_next = 1'b0;

  dsrs_out_t pending_reports[$];
  tick_row_t tick_rows[$];

  int unsigned mismatches = 0;
  int unsigned ticks_taken = 0;
  int unsigned reports_seen = 0;
  int unsigned settings_used = 1;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  bit want_hold = 1'b0;

  logic [TimeWidth-1:0] sim_ms = '0;
  logic raw_level = 1'b0;
  int drift_temp = 0;

  // Returns 1 and the report when this tick causes one; updates the mirror state.
  function automatic bit schedule_report(input dsrs_in_t tick, output dsrs_out_t rpt);
    logic [TimeWidth-1:0] now;
    logic [TimeWidth-1:0] age;
    logic [TimeWidth-1:0] since;
    logic [1:0] level;
    int temp_gap;
    now = tick.time_ms;
    level = {1'b0, tick.raw_status ^ invert_set};
    rpt = '0;
    if (tick.temp_valid) temp_now = tick.temp_sample;
    if (level != seen_raw) begin
      raw_since = now;
      seen_raw = level;
    end
    age = now - raw_since;
    if (age > debounce_set) settled_status = level;
    since = now - last_sent_ms;
    if (since <= min_gap_set) return 1'b0;
    rpt.status_value = settled_status;
    rpt.temp_value = temp_now;
    if (settled_status != sent_status) begin
      sent_status = settled_status;
      last_sent_ms = now;
      rpt.report_kind = KindStatus;
      return 1'b1;
    end
    temp_gap = int'(temp_now) - int'(sent_temp);
    if (temp_gap < 0) temp_gap = -temp_gap;
    if (temp_gap > int'(threshold_set)) begin
      sent_temp = temp_now;
      last_sent_ms = now;
      rpt.report_kind = KindTemp;
      return 1'b1;
    end
    if (since > periodic_set) begin
      if (temp_turn_next == KindStatus) sent_status = settled_status;
      else sent_temp = temp_now;
      rpt.report_kind = temp_turn_next;
      temp_turn_next = ~temp_turn_next;
      last_sent_ms = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i) begin
    dsrs_out_t rpt;
    bit has;
    if (rst_ni && in_valid_i && in_ready_o) begin
      has = schedule_report(in_data_i, rpt);
      if (tick_src == Tabulated) begin
        has = tick_has;
        rpt = tick_rpt;
      end
      if (has) pending_reports.push_back(rpt);
      ticks_taken++;
    end
  end

  always @(posedge clk_i) begin
    dsrs_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("report with none expected: kind %0d status %0d temp %0d",
               out_data_o.report_kind, out_data_o.status_value, out_data_o.temp_value);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (out_data_o.report_kind !== want.report_kind) begin
          $error("report_kind: expected %0d, got %0d", want.report_kind,
                 out_data_o.report_kind);
          mismatches++;
        end
        if (out_data_o.status_value !== want.status_value) begin
          $error("status_value: expected %0d, got %0d", want.status_value,
                 out_data_o.status_value);
          mismatches++;
        end
        if (out_data_o.temp_value !== want.temp_value) begin
          $error("temp_value: expected %0d, got %0d", want.temp_value,
                 out_data_o.temp_value);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (want_hold) begin
      out_ready_i <= 1'b0;
      hold_left = HoldCycles;
      want_hold = 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_tick(dsrs_in_t tick, row_src_e src, bit has, dsrs_out_t rpt);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= tick;
    tick_src <= src;
    tick_has <= has;
    tick_rpt <= rpt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle(int unsigned extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgDebounce:  debounce_set = data[DebounceWidth-1:0];
      CfgMinGap:    min_gap_set = data[GapWidth-1:0];
      CfgPeriodic:  periodic_set = data[GapWidth-1:0];
      CfgThreshold: threshold_set = data[TempWidth-1:0];
      CfgInvert:    invert_set = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(logic [TimeWidth-1:0] ms, logic raw, logic tv,
                         logic signed [TempWidth-1:0] sample, row_src_e src, bit has,
                         logic kind, logic [1:0] status, logic signed [TempWidth-1:0] temp);
    tick_row_t row;
    row.tick = '{time_ms: ms, raw_status: raw, temp_valid: tv, temp_sample: sample};
    row.src = src;
    row.has_rpt = has;
    row.rpt = '{report_kind: kind, status_value: status, temp_value: temp};
    tick_rows.push_back(row);
  endtask

  // Random ticks: the raw status is held for runs so debounce can settle, the
  // temperature drifts in steps scaled to the threshold, with rare jumps anywhere.
  task automatic run_phase(int unsigned n, int unsigned max_step, int pause_at);
    dsrs_in_t tick;
    int unsigned pick;
    int spread;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) settle(0);
      pick = $urandom_range(99);
      if (pick < 3) sim_ms = $urandom();
      else sim_ms = sim_ms + $urandom_range(max_step);
      if ($urandom_range(7) == 0) raw_level = ~raw_level;
      spread = (threshold_set > 30) ? 40 : int'(threshold_set) + 6;
      drift_temp = drift_temp + int'($urandom_range(2 * spread)) - spread;
      if (drift_temp > 1270) drift_temp = 1270;
      if (drift_temp < -1280) drift_temp = -1280;
      tick.time_ms = sim_ms;
      tick.raw_status = raw_level;
      tick.temp_valid = 1'($urandom_range(1));
      if (pick >= 90 || !tick.temp_valid) tick.temp_sample = TempWidth'($urandom());
      else tick.temp_sample = drift_temp[TempWidth-1:0];
      send_tick(tick, Predicted, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned send_pcts[6];
    int unsigned recv_pcts[6];
    int unsigned min_gap;
    send_pcts = '{0, 26, 0, 47, 0, 26};
    recv_pcts = '{47, 26, 0, 0, 47, 26};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // writes past the register list must change nothing
    write_reg(CfgSpareFirst, '1);
    write_reg(CfgSpareLast, '1);

    // Defaults: debounce 100, min gap 1000, periodic 60000, threshold 5.
    // First tick: nothing settled yet, so the periodic report carries unknown.
    add_row(32'd60001, 1'b0, 1'b0, 12'sd0, Tabulated, 1'b1, KindStatus, StatusUnknown,
            TempReset);
    // gap equal to the minimum is not enough
    add_row(32'd61001, 1'b0, 1'b0, 12'sd0, Tabulated, 1'b0, KindStatus, StatusOff, 12'sd0);
    add_row(32'd61002, 1'b0, 1'b0, 12'sd0, Tabulated, 1'b1, KindStatus, StatusOff,
            TempReset);
    add_row(32'd62003, 1'b0, 1'b1, 12'sd1270, Tabulated, 1'b1, KindTemp, StatusOff,
            12'sd1270);
    add_row(32'd63004, 1'b0, 1'b1, -12'sd2048, Tabulated, 1'b1, KindTemp, StatusOff,
            -12'sd2048);
    add_row(32'd64005, 1'b0, 1'b1, 12'sd2047, Tabulated, 1'b1, KindTemp, StatusOff,
            12'sd2047);
    add_row(32'd64011, 1'b1, 1'b0, 12'sd0, Tabulated, 1'b0, KindStatus, StatusOff, 12'sd0);
    // stable for exactly the debounce time: not yet accepted
    add_row(32'd64111, 1'b1, 1'b0, 12'sd0, Tabulated, 1'b0, KindStatus, StatusOff, 12'sd0);
    add_row(32'd65006, 1'b1, 1'b0, 12'sd0, Tabulated, 1'b1, KindStatus, StatusOn,
            12'sd2047);
    // change equal to the threshold does not report
    add_row(32'd66007, 1'b1, 1'b1, 12'sd2042, Tabulated, 1'b0, KindStatus, StatusOn, 12'sd0);
    add_row(32'd67008, 1'b1, 1'b1, 12'sd2041, Tabulated, 1'b1, KindTemp, StatusOn,
            12'sd2041);
    // periodic reports alternate; the turn was left on temperature by the first one
    add_row(32'd127009, 1'b1, 1'b0, 12'sd0, Tabulated, 1'b1, KindTemp, StatusOn, 12'sd2041);
    add_row(32'd187010, 1'b1, 1'b0, 12'sd0, Tabulated, 1'b1, KindStatus, StatusOn,
            12'sd2041);
    // one ms backwards wraps to a huge gap
    add_row(32'd187009, 1'b1, 1'b0, 12'sd0, Tabulated, 1'b1, KindTemp, StatusOn, 12'sd2041);
    add_row(32'hFFFF_FFFF, 1'b0, 1'b1, -12'sd1, Predicted, 1'b0, KindStatus, StatusOff, 12'sd0);
    add_row(32'd0, 1'b0, 1'b0, 12'sd0, Predicted, 1'b0, KindStatus, StatusOff, 12'sd0);
    add_row(32'd101, 1'b0, 1'b0, 12'sd0, Predicted, 1'b0, KindStatus, StatusOff, 12'sd0);
    add_row(32'd1001, 1'b0, 1'b0, 12'sd0, Predicted, 1'b0, KindStatus, StatusOff, 12'sd0);
    // sample ignored while temp_valid is low
    add_row(32'd2002, 1'b1, 1'b0, 12'sh7FF, Predicted, 1'b0, KindStatus, StatusOff, 12'sd0);
    add_row(32'd2003, 1'b0, 1'b0, -12'sd2048, Predicted, 1'b0, KindStatus, StatusOff, 12'sd0);
    add_row(32'd3004, 1'b0, 1'b1, 12'sd3, Predicted, 1'b0, KindStatus, StatusOff, 12'sd0);
    add_row(32'd4005, 1'b1, 1'b1, -12'sd1280, Predicted, 1'b0, KindStatus, StatusOff, 12'sd0);

    foreach (tick_rows[i])
      send_tick(tick_rows[i].tick, tick_rows[i].src, tick_rows[i].has_rpt, tick_rows[i].rpt);
    settle(DrainCycles);
    sim_ms = 32'd5000;

    // all-zero settings: nearly every tick reports; long receiver hold-off
    write_reg(CfgDebounce, '0);
    write_reg(CfgMinGap, '0);
    write_reg(CfgPeriodic, '0);
    write_reg(CfgThreshold, '0);
    write_reg(CfgInvert, '0);
    settings_used++;
    want_hold = 1'b1;
    run_phase(90, 3, -1);
    settle(DrainCycles);

    // all-ones settings, inverted status, long time steps
    write_reg(CfgDebounce, 24'h00FFFF);
    write_reg(CfgMinGap, 24'hFFFFFF);
    write_reg(CfgPeriodic, 24'hFFFFFF);
    write_reg(CfgThreshold, 24'h000FFF);
    write_reg(CfgInvert, 24'h000001);
    settings_used++;
    send_idle_pct = 47;
    run_phase(60, 32'h0200_0000, -1);
    settle(DrainCycles);

    for (int p = 0; p < 6; p++) begin
      min_gap = $urandom_range(25);
      // upper data bits beyond each register's width are don't-care
      write_reg(CfgDebounce, {8'($urandom()), 16'($urandom_range(40))});
      write_reg(CfgMinGap, 24'(min_gap));
      write_reg(CfgPeriodic, 24'($urandom_range(150)));
      write_reg(CfgThreshold, {12'($urandom()), 12'($urandom_range(30))});
      write_reg(CfgInvert, 24'($urandom()));
      settings_used++;
      send_idle_pct = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      if (p == 2) sim_ms = 32'hFFFF_FF80;
      run_phase(83, 2 * min_gap + 4, (p == 0) ? 40 : -1);
      settle(DrainCycles);
    end

    $display("Run covered %0d ticks and %0d reports over %0d register settings,",
             ticks_taken, reports_seen, settings_used);
    $display("including time wrap, backward time stamps and a long output stall.");
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
